>>> hw/rtl/lru_ttl_address_cache_top_defines.svh
// assertion macros for the address cache
`ifndef LRU_TTL_ADDRESS_CACHE_TOP_DEFINES_SVH
`define LRU_TTL_ADDRESS_CACHE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LTTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LTTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lttc_pkg.sv
// shared types and constants of the address cache
package lttc_pkg;

  localparam int LTTC_ENTRIES = 64;

  localparam logic [15:0] QTYPE_A    = 16'd1;
  localparam logic [15:0] QTYPE_AAAA = 16'd28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_FINISH,
    ST_DONE
  } lttc_state_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] ip;
    logic [32:0] expiry;
  } lttc_entry_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic sweep;
    logic rd;
    logic eval;
    logic fin;
    logic emit;
  } lttc_cmd_t;

  typedef struct packed {
    logic is_store;
    logic lookup_ok;
    logic full;
    logic r_done;
    logic out_busy;
  } lttc_status_t;

endpackage

>>> hw/rtl/lttc_if.sv
// channel interfaces of the address cache
interface lttc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] name_key;
  logic [15:0] query_type;
  logic [31:0] ip_value;
  logic [31:0] ttl_seconds;
  logic [31:0] now_seconds;

  modport source (output valid, kind, name_key, query_type, ip_value, ttl_seconds,
                  now_seconds, input ready);
  modport sink (input valid, kind, name_key, query_type, ip_value, ttl_seconds,
                now_seconds, output ready);
endinterface

interface lttc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] answer_ip;
  logic [31:0] ttl_left;

  modport source (output valid, hit, answer_ip, ttl_left, input ready);
  modport sink (input valid, hit, answer_ip, ttl_left, output ready);
endinterface

>>> hw/rtl/lttc_ctrl.sv
// controller state machine of the address cache
module lttc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  lttc_pkg::lttc_status_t st,
  output lttc_pkg::lttc_cmd_t    cmd,
  output lttc_pkg::lttc_state_t  state
);
  import lttc_pkg::*;

  lttc_state_t state_r, state_nxt;

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st.lookup_ok || (st.is_store && st.full)) begin
          cmd.sweep = 1'b1;
          state_nxt = ST_READ;
        end else if (st.is_store) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        if (st.r_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_FINISH: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/lttc_dp.sv
// datapath of the address cache: entry memory, sweep pointers, result register
module lttc_dp #(
  parameter int ENTRIES = lttc_pkg::LTTC_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lttc_pkg::lttc_cmd_t    cmd,
  output lttc_pkg::lttc_status_t st,
  lttc_in_if.sink               in_chan,
  lttc_out_if.source            out_chan
);
  import lttc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  lttc_entry_t mem [ENTRIES];

  logic [CW-1:0] count_r, r_r, w_r, rd_pos_r;
  logic          found_r;
  lttc_entry_t   saved_r, rd_data_r;
  logic          kind_r;
  logic [63:0]   key_r;
  logic [15:0]   qtype_r;
  logic [31:0]   ip_r;
  logic [31:0]   now_r;
  logic [32:0]   exp_new_r;
  logic          out_valid_r, hit_r;
  logic [31:0]   ans_r, ttl_r;

  logic          keep, match, expired;
  logic          we;
  logic [IW-1:0] wa;
  lttc_entry_t   wd;
  logic [32:0]   left;

  assign st.is_store  = !kind_r;
  assign st.lookup_ok = kind_r && (qtype_r == QTYPE_A || qtype_r == QTYPE_AAAA);
  assign st.full      = (count_r == CW'(ENTRIES));
  assign st.r_done    = (r_r == count_r);
  assign st.out_busy  = out_valid_r && !out_chan.ready;

  assign in_chan.ready = cmd.accept;

  // sweep decision on the registered read data
  always_comb begin
    expired = (rd_data_r.expiry <= {1'b0, now_r});
    match   = kind_r && !found_r && !expired && (rd_data_r.key == key_r);
    if (!kind_r) begin
      keep = (rd_pos_r != '0);
    end else if (!found_r) begin
      keep = !expired && !match;
    end else begin
      keep = 1'b1;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = w_r[IW-1:0];
    wd = rd_data_r;
    if (cmd.eval) begin
      we = keep;
    end else if (cmd.fin) begin
      we = !kind_r || found_r;
      wd = kind_r ? saved_r : lttc_entry_t'{key: key_r, ip: ip_r, expiry: exp_new_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[r_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      r_r         <= '0;
      w_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        r_r     <= count_r;
        w_r     <= count_r;
        found_r <= 1'b0;
      end
      if (cmd.sweep) begin
        r_r <= '0;
        w_r <= '0;
      end
      if (cmd.rd) begin
        r_r <= r_r + CW'(1);
      end
      if (cmd.eval) begin
        if (keep) begin
          w_r <= w_r + CW'(1);
        end
        if (match) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.fin) begin
        count_r <= (!kind_r || found_r) ? w_r + CW'(1) : w_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign left = saved_r.expiry - {1'b0, now_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_chan.kind;
      key_r     <= in_chan.name_key;
      qtype_r   <= in_chan.query_type;
      ip_r      <= in_chan.ip_value;
      now_r     <= in_chan.now_seconds;
      exp_new_r <= {1'b0, in_chan.now_seconds} + {1'b0, in_chan.ttl_seconds};
    end
    if (cmd.rd) begin
      rd_pos_r <= r_r;
    end
    if (cmd.eval && match) begin
      saved_r <= rd_data_r;
    end
    if (cmd.emit) begin
      hit_r <= found_r;
      ans_r <= found_r ? saved_r.ip : '0;
      ttl_r <= found_r ? (left[32] ? 32'hFFFF_FFFF : left[31:0]) : '0;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.hit       = hit_r;
  assign out_chan.answer_ip = ans_r;
  assign out_chan.ttl_left  = ttl_r;
endmodule

>>> hw/rtl/lru_ttl_address_cache_top.sv
// top level of the name-to-address cache with recency order and expiry
// One transaction at a time. A store into a cache that is not full passes from
// acceptance through the dispatch, finish and done states. A lookup of type A or
// AAAA, and a store into a full cache, sweeps the entry memory once from oldest to
// newest, a read state and an evaluation state per stored entry through the single
// read port with registered read data, then passes through the finish and done
// states. Other lookups go from dispatch straight to the done state. A result held
// back by the receiver keeps the block in its done state until the result register
// frees up. Entries stay compacted in age order: the sweep copies survivors down;
// a lookup drops expired entries met before the match (or all of them on a miss),
// a store into a full cache drops only the oldest entry, and the matched entry, or
// the new one, is written at the newest end. No clearing pass after reset: only
// positions below the entry count are ever read.
module lru_ttl_address_cache_top #(
  parameter int ENTRIES = lttc_pkg::LTTC_ENTRIES
) (
  input logic        clk,
  input logic        rst_n,
  lttc_in_if.sink    in_chan,
  lttc_out_if.source out_chan
);
  import lttc_pkg::*;
  `include "lru_ttl_address_cache_top_defines.svh"

  // command and status between controller and datapath
  lttc_cmd_t    cmd;
  lttc_status_t st;
  lttc_state_t  state;

  lttc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .st       (st),
    .cmd      (cmd),
    .state    (state)
  );

  lttc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // an accepted transaction keeps the block busy in the next cycle
  `LTTC_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready, "ready after accept")
  // evaluation always follows a memory read
  `LTTC_ASSERT_SAME(a_eval_after_read, cmd.eval, $past(cmd.rd), "eval without read")
  // at most one datapath step per cycle
  `LTTC_ASSERT_SAME(a_one_step, 1'b1, $onehot0({cmd.sweep, cmd.rd, cmd.eval, cmd.fin, cmd.emit}), "steps overlap")
  // a result is only emitted from the done state
  `LTTC_ASSERT_SAME(a_emit_done, cmd.emit, state == ST_DONE, "emit outside done")
endmodule
